// ----- rtl/core/stpd_pkg.sv -----
`timescale 1ns / 1ps
package stpd_pkg;

    localparam int SINE_TABLE_DEPTH = 1024;
    localparam int PHASE_BITS       = 32;

    localparam int POS_W  = 32;
    localparam int VEL_W  = 48;
    localparam int SIN_W  = 17;
    localparam int CFG_W  = 32;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_KP     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KD     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_AMP    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_STEP   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ALPHA  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_BIAS   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_CLAMP  = 3'd7;

    localparam logic [31:0] TWO_PI_Q28 = 32'd1686629713;

    // datapath steps, one per cycle
    localparam int STEP_W = 3;
    localparam logic [STEP_W-1:0] DP_LOAD  = 3'd0;
    localparam logic [STEP_W-1:0] DP_MUL1  = 3'd1;
    localparam logic [STEP_W-1:0] DP_MUL2  = 3'd2;
    localparam logic [STEP_W-1:0] DP_MUL3  = 3'd3;
    localparam logic [STEP_W-1:0] DP_MUL4  = 3'd4;
    localparam logic [STEP_W-1:0] DP_MUL5  = 3'd5;
    localparam logic [STEP_W-1:0] DP_FINAL = 3'd6;
    localparam logic [STEP_W-1:0] DP_CLAMP = 3'd7;

    typedef struct packed {
        logic                load;
        logic                run;
        logic [STEP_W-1:0]   step;
    } dp_cmd_t;

    // reciprocals of the taylor divisors 6, 20, 42, 72, 110, 156 with a 42-bit shift,
    // exact floor for dividends below 2^33
    localparam int RCP_SH = 42;
    localparam logic [5:0][43:0] TAYLOR_RCP = {
        44'(((64'd1 << 42) + 64'd155) / 64'd156),
        44'(((64'd1 << 42) + 64'd109) / 64'd110),
        44'(((64'd1 << 42) + 64'd71) / 64'd72),
        44'(((64'd1 << 42) + 64'd41) / 64'd42),
        44'(((64'd1 << 42) + 64'd19) / 64'd20),
        44'(((64'd1 << 42) + 64'd5) / 64'd6)
    };

    // quarter-wave sine in Q1.15 from a seven-term taylor series, depth a power of two
    function automatic logic [SIN_W-1:0] sine_entry(input int unsigned i, input int unsigned depth);
        logic [63:0] x, x2, term;
        logic [127:0] prod;
        logic signed [63:0] sum, e;
        begin
            x = (64'd1686629713 * 64'(i)) >> $clog2(depth);
            x2 = (x * x) >> 30;
            term = x;
            sum = $signed(x);
            for (int k = 1; k <= 6; k++) begin
                prod = 128'((term * x2) >> 30) * 128'(TAYLOR_RCP[k-1]);
                term = 64'(prod >> RCP_SH);
                if ((k & 1) != 0) sum = sum - $signed(term);
                else sum = sum + $signed(term);
            end
            if (sum < 0) sum = 0;
            e = $signed((64'(sum) + 64'd16384) >> 15);
            if (e > 32768) e = 32768;
            sine_entry = e[SIN_W-1:0];
        end
    endfunction

endpackage

// ----- rtl/core/stpd_ctrl.sv -----
`timescale 1ns / 1ps
module stpd_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    output stpd_pkg::dp_cmd_t cmd
);
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0] state_reg, state_next;
    logic [stpd_pkg::STEP_W-1:0] step_reg, step_next;

    // a new transaction enters while idle or as the waiting result leaves
    assign in_ready  = (state_reg == ST_IDLE) || (state_reg == ST_DONE && out_ready);
    assign out_valid = (state_reg == ST_DONE);

    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        cmd.load   = in_valid && in_ready;
        cmd.run    = (state_reg == ST_RUN);
        cmd.step   = step_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    state_next = ST_RUN;
                    step_next  = stpd_pkg::DP_MUL1;
                end
            end
            ST_RUN: begin
                if (step_reg == stpd_pkg::DP_CLAMP) state_next = ST_DONE;
                else step_next = step_reg + 1'b1;
            end
            ST_DONE: begin
                if (out_ready) begin
                    if (in_valid) begin
                        state_next = ST_RUN;
                        step_next  = stpd_pkg::DP_MUL1;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            step_reg  <= stpd_pkg::DP_LOAD;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end
endmodule

// ----- rtl/core/stpd_dp.sv -----
`timescale 1ns / 1ps
module stpd_dp #(
    parameter int SINE_TABLE_DEPTH = stpd_pkg::SINE_TABLE_DEPTH,
    parameter int PHASE_BITS       = stpd_pkg::PHASE_BITS
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  stpd_pkg::dp_cmd_t        cmd,
    input  logic signed [31:0]       position_counts,
    input  logic                     restart,
    input  logic signed [23:0]       kp_gain,
    input  logic signed [23:0]       kd_gain,
    input  logic [19:0]              amplitude_counts,
    input  logic signed [20:0]       offset_counts,
    input  logic [PHASE_BITS-1:0]    phase_step,
    input  logic [16:0]              alpha_weight,
    input  logic signed [10:0]       bias_permille,
    input  logic [9:0]               clamp_permille,
    output logic signed [10:0]       torque_permille,
    output logic                     clamped,
    output logic signed [21:0]       desired_counts
);
    localparam int QS    = PHASE_BITS - 2;
    localparam int AW    = $clog2(SINE_TABLE_DEPTH);
    localparam int OMW   = PHASE_BITS + 32;

    logic [stpd_pkg::SIN_W-1:0] rom [0:SINE_TABLE_DEPTH];
    for (genvar g = 0; g <= SINE_TABLE_DEPTH; g++) begin : g_rom
        assign rom[g] = stpd_pkg::sine_entry(g, SINE_TABLE_DEPTH);
    end

    // architectural state
    logic signed [31:0] ref_reg, prev_reg;
    logic signed [47:0] vel_reg;
    logic [PHASE_BITS-1:0] phase_reg;

    // working registers
    logic signed [31:0] d_reg, rel_reg;
    logic [PHASE_BITS-1:0] ph_reg;
    logic signed [17:0] s_reg, c_reg;
    logic signed [37:0] as_reg;
    logic [OMW-1:0] om_reg;
    logic signed [66:0] vf_reg;
    logic signed [57:0] av_reg;
    logic signed [47:0] vd_reg;
    logic signed [48:0] ev_reg;
    logic signed [56:0] kpe_reg, kdh_reg;
    logic signed [40:0] kdl_reg;
    logic signed [66:0] tot_reg;
    logic signed [10:0] torque_reg;
    logic clamped_reg;
    logic signed [21:0] desired_reg;

    function automatic logic signed [17:0] sine_at(input logic [PHASE_BITS-1:0] p);
        logic [QS-1:0] frac;
        logic [AW:0] idx;
        logic [1:0] q;
        logic [stpd_pkg::SIN_W-1:0] v;
        begin
            frac = p[QS-1:0];
            q    = p[PHASE_BITS-1:QS];
            idx  = {1'b0, frac[QS-1 -: AW]};
            v = q[0] ? rom[SINE_TABLE_DEPTH - int'(idx)] : rom[idx];
            sine_at = q[1] ? -$signed({1'b0, v}) : $signed({1'b0, v});
        end
    endfunction

    function automatic logic signed [66:0] rnd67(input logic signed [66:0] v, input int sh);
        logic [66:0] mag;
        begin
            mag = v[66] ? 67'(-v) : 67'(v);
            mag = (mag + (67'd1 << (sh - 1))) >> sh;
            rnd67 = v[66] ? -$signed(mag) : $signed(mag);
        end
    endfunction

    logic [16:0] alpha_c;
    logic signed [31:0] d_now;
    logic signed [47:0] vel_base;
    logic signed [66:0] vnew_c, avr_c, vdr_c, tot_c;
    logic signed [21:0] des_c;
    logic signed [57:0] sum_c;
    logic signed [26:0] cmd_c;
    logic signed [10:0] lim_c;
    logic [35:0] wq_c;
    logic signed [32:0] hi_c;
    logic signed [16:0] lo_c;

    assign alpha_c = alpha_weight[16] ? 17'd65536 : alpha_weight;
    assign lim_c = (clamp_permille > 10'd1000) ? 11'sd1000 : $signed({1'b0, clamp_permille});

    always_comb begin
        d_now  = restart ? 32'sd0 : position_counts - prev_reg;
        vel_base = vel_reg;
        vnew_c = rnd67(vf_reg, 16);
        des_c  = 22'(offset_counts) + 22'(rnd67(67'(as_reg), 15));
        wq_c   = 36'((om_reg + (OMW'(1) << (PHASE_BITS - 5))) >> (PHASE_BITS - 4));
        avr_c  = rnd67(67'(av_reg), 16);
        vdr_c  = rnd67(67'(vd_reg) * 67'(c_reg), 15);
        hi_c   = 33'(ev_reg >>> 16);
        lo_c   = $signed({1'b0, ev_reg[15:0]});
        sum_c  = 58'(kpe_reg) + 58'(kdh_reg);
        if (sum_c > (58'sd1 <<< 40)) sum_c = 58'sd1 <<< 40;
        if (sum_c < -(58'sd1 <<< 40)) sum_c = -(58'sd1 <<< 40);
        tot_c  = (67'(sum_c) <<< 16) + 67'(kdl_reg) + (67'(bias_permille) <<< 32);
        cmd_c  = 27'(rnd67(tot_reg, 32));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ref_reg   <= '0;
            prev_reg  <= '0;
            vel_reg   <= '0;
            phase_reg <= '0;
        end else if (cmd.load) begin
            d_reg   <= d_now;
            rel_reg <= restart ? 32'sd0 : position_counts - ref_reg;
            ph_reg  <= restart ? '0 : phase_reg;
            prev_reg <= position_counts;
            if (restart) begin
                ref_reg <= position_counts;
                vel_reg <= '0;
            end
        end else if (cmd.run) begin
            unique case (cmd.step)
                stpd_pkg::DP_MUL1: begin
                    s_reg  <= sine_at(ph_reg);
                    c_reg  <= sine_at(ph_reg + (PHASE_BITS'(1) << QS));
                    om_reg <= OMW'(phase_step) * OMW'(stpd_pkg::TWO_PI_Q28);
                    vf_reg <= 67'($signed({1'b0, alpha_c})) * (67'(d_reg) <<< 16);
                end
                stpd_pkg::DP_MUL2: begin
                    as_reg <= $signed({1'b0, amplitude_counts}) * s_reg;
                    av_reg <= 58'($signed({1'b0, amplitude_counts})) * 58'($signed({1'b0, wq_c}));
                    vf_reg <= vf_reg + 67'($signed(18'd65536 - {1'b0, alpha_c})) * 67'(vel_base);
                end
                stpd_pkg::DP_MUL3: begin
                    desired_reg <= des_c;
                    vd_reg  <= 48'(avr_c);
                    vel_reg <= 48'(vnew_c);
                    phase_reg <= ph_reg + phase_step;
                end
                stpd_pkg::DP_MUL4: begin
                    ev_reg  <= 49'(vdr_c) - 49'(vel_reg);
                    kpe_reg <= 57'(kp_gain) * (57'(desired_reg) - 57'(rel_reg));
                end
                stpd_pkg::DP_MUL5: begin
                    kdh_reg <= 57'(kd_gain) * 57'(hi_c);
                    kdl_reg <= 41'(kd_gain) * 41'(lo_c);
                end
                stpd_pkg::DP_FINAL: begin
                    tot_reg <= tot_c;
                end
                stpd_pkg::DP_CLAMP: begin
                    clamped_reg <= (cmd_c > 27'(lim_c)) || (cmd_c < -27'(lim_c));
                    if (cmd_c > 27'(lim_c)) torque_reg <= lim_c;
                    else if (cmd_c < -27'(lim_c)) torque_reg <= -lim_c;
                    else torque_reg <= 11'(cmd_c);
                end
                default: ;
            endcase
        end
    end

    assign torque_permille = torque_reg;
    assign clamped         = clamped_reg;
    assign desired_counts  = desired_reg;
endmodule

// ----- rtl/core/sine_tracking_pd_torque.sv -----
`timescale 1ns / 1ps
// channel | dir | tdata fields (low bit up)                | tuser
// s_      | in  | position_counts[31:0]                    | restart
// m_      | out | torque_permille[10:0], clamped, desired_counts[21:0], pad | -
// m_tvalid rises after the seven datapath steps that follow the accept: one register
// after each multiply, the sum and the rounding with clamp.
// a new transaction is not taken while one is in flight; it enters only while idle or
// at the edge where the waiting result leaves, so a stalled m_tready blocks s_tready.
// reset (aresetn low, synchronous) clears state, phase, velocity and past position.
module sine_tracking_pd_torque #(
    parameter int SINE_TABLE_DEPTH = stpd_pkg::SINE_TABLE_DEPTH,
    parameter int PHASE_BITS       = stpd_pkg::PHASE_BITS
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,  // position_counts
    input  logic        s_tuser,  // restart
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,  // torque_permille, clamped, desired_counts
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_wdata
);
    logic signed [23:0] kp_reg, kd_reg;
    logic [19:0] amp_reg;
    logic signed [20:0] off_reg;
    logic [31:0] step_reg;
    logic [16:0] alpha_reg;
    logic signed [10:0] bias_reg;
    logic [9:0] clamp_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kp_reg <= '0; kd_reg <= '0; amp_reg <= 20'd455; off_reg <= '0;
            step_reg <= 32'd4294967; alpha_reg <= 17'd13107; bias_reg <= '0;
            clamp_reg <= 10'd400;
        end else if (cfg_we) begin
            unique case (cfg_index)
                stpd_pkg::REG_KP:     kp_reg    <= cfg_wdata[23:0];
                stpd_pkg::REG_KD:     kd_reg    <= cfg_wdata[23:0];
                stpd_pkg::REG_AMP:    amp_reg   <= cfg_wdata[19:0];
                stpd_pkg::REG_OFFSET: off_reg   <= cfg_wdata[20:0];
                stpd_pkg::REG_STEP:   step_reg  <= cfg_wdata;
                stpd_pkg::REG_ALPHA:  alpha_reg <= cfg_wdata[16:0];
                stpd_pkg::REG_BIAS:   bias_reg  <= cfg_wdata[10:0];
                stpd_pkg::REG_CLAMP:  clamp_reg <= cfg_wdata[9:0];
                default: ;
            endcase
        end
    end

    stpd_pkg::dp_cmd_t cmd;
    logic signed [10:0] torque;
    logic clamped;
    logic signed [21:0] desired;

    stpd_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_tvalid), .in_ready(s_tready),
        .out_valid(m_tvalid), .out_ready(m_tready), .cmd(cmd)
    );

    stpd_dp #(.SINE_TABLE_DEPTH(SINE_TABLE_DEPTH), .PHASE_BITS(PHASE_BITS)) u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd),
        .position_counts(s_tdata), .restart(s_tuser),
        .kp_gain(kp_reg), .kd_gain(kd_reg), .amplitude_counts(amp_reg),
        .offset_counts(off_reg), .phase_step(PHASE_BITS'(step_reg)),
        .alpha_weight(alpha_reg), .bias_permille(bias_reg), .clamp_permille(clamp_reg),
        .torque_permille(torque), .clamped(clamped), .desired_counts(desired)
    );

    assign m_tdata = {6'd0, desired, clamped, torque};
endmodule

// ----- rtl/core/stpd_checker.sv -----
`timescale 1ns / 1ps
module stpd_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata
);
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)) else $error("result dropped");
    a_lat: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !m_tvalid) else $error("result too early");
    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ($signed(m_tdata[10:0]) <= 11'sd1000 && $signed(m_tdata[10:0]) >= -11'sd1000))
        else $error("torque out of range");
    a_pad: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[39:34] == 6'd0)
        else $error("pad bits set");
endmodule

bind sine_tracking_pd_torque stpd_checker u_chk (
    .aclk(aclk), .aresetn(aresetn), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);
